// ----- rtl/core/omd_pkg.sv -----
// ----------------------------------------------------------------------------
// omd_pkg
// Types and constants shared by the message deframer's files.
// ----------------------------------------------------------------------------
package omd_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_OBFUSCATION_ON = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_TYPE      = 8'd1;

  localparam logic [31:0] TYPE_SIZE_NARROW = 32'd1;
  localparam logic [31:0] TYPE_SIZE_WIDE   = 32'd4;
  localparam logic [1:0]  GROUP_LAST_POS   = 2'd3;

  typedef enum logic [2:0] {
    PH_KEY,
    PH_LEN,
    PH_TYPE,
    PH_PAY,
    PH_DROP
  } omd_phase_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic [31:0] msg_type;
    logic [31:0] payload_length;
    logic        last;
    logic        malformed;
  } omd_result_t;

endpackage

// ----- rtl/core/omd_byte_if.sv -----
// ----------------------------------------------------------------------------
// omd_byte_if
// Byte stream channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface omd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/core/omd_result_if.sv -----
// ----------------------------------------------------------------------------
// omd_result_if
// Result channel of the deframer with valid/ready handshake.
// ----------------------------------------------------------------------------
interface omd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        has_byte;
  logic [31:0] msg_type;
  logic [31:0] payload_length;
  logic        last;
  logic        malformed;

  modport source (output valid, output payload_byte, output has_byte, output msg_type,
                  output payload_length, output last, output malformed, input ready);
  modport sink   (input valid, input payload_byte, input has_byte, input msg_type,
                  input payload_length, input last, input malformed, output ready);
endinterface

// ----- rtl/core/omd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// omd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface omd_cfg_if;
  import omd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// ----- rtl/core/omd_in_reg.sv -----
// ----------------------------------------------------------------------------
// omd_in_reg
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module omd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       fire,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ----- rtl/core/omd_parse_core.sv -----
// ----------------------------------------------------------------------------
// omd_parse_core
// Frame parser state, descrambling and result formation for one byte.
// ----------------------------------------------------------------------------
module omd_parse_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [omd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [omd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            fire,
  input  logic [7:0]                      in_byte,
  output logic                            res_valid,
  output omd_pkg::omd_result_t            res
);
  import omd_pkg::*;

  logic       obfuscation_on;
  logic       wide_type;
  omd_phase_t phase;
  logic [1:0] byte_in_group;
  logic [31:0] rolling_key;
  logic [31:0] frame_length;
  logic [31:0] bytes_left;
  logic [31:0] type_accumulator;

  omd_phase_t  phase_next;
  logic [1:0]  byte_in_group_next;
  logic [31:0] rolling_key_next;
  logic [31:0] frame_length_next;
  logic [31:0] bytes_left_next;
  logic [31:0] type_accumulator_next;

  logic [4:0]  shift;
  logic [31:0] type_size;
  logic [31:0] key_used;
  logic [7:0]  plain;
  logic [31:0] len_merged;
  logic [31:0] type_merged;
  logic [31:0] plen;
  logic [31:0] left_dec;
  logic        type_done;
  omd_phase_t  start_phase;

  assign shift       = {byte_in_group, 3'b000};
  assign type_size   = wide_type ? TYPE_SIZE_WIDE : TYPE_SIZE_NARROW;
  assign type_done   = wide_type ? (byte_in_group == GROUP_LAST_POS) : (byte_in_group == 2'd0);
  assign start_phase = obfuscation_on ? PH_KEY : PH_LEN;

  // The key turns left by one bit at the first byte of each group.
  assign key_used = (obfuscation_on && byte_in_group == 2'd0) ?
                    {rolling_key[30:0], rolling_key[31]} : rolling_key;
  assign plain    = obfuscation_on ? (in_byte ^ key_used[shift +: 8]) : in_byte;

  assign len_merged  = (frame_length & ~(32'h0000_00ff << shift)) | ({24'd0, plain} << shift);
  assign type_merged = type_accumulator | ({24'd0, plain} << shift);
  assign plen        = frame_length - type_size;
  assign left_dec    = bytes_left - 32'd1;

  always_comb begin
    phase_next            = phase;
    byte_in_group_next    = byte_in_group + 2'd1;
    rolling_key_next      = rolling_key;
    frame_length_next     = frame_length;
    bytes_left_next       = bytes_left;
    type_accumulator_next = type_accumulator;
    res_valid             = 1'b0;
    res                   = '0;

    if (phase != PH_KEY) begin
      rolling_key_next = key_used;
    end

    case (phase)
      PH_KEY: begin
        rolling_key_next = (rolling_key & ~(32'h0000_00ff << shift)) |
                           ({24'd0, in_byte} << shift);
        if (byte_in_group == GROUP_LAST_POS) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        frame_length_next = len_merged;
        if (byte_in_group == GROUP_LAST_POS) begin
          if (len_merged < type_size) begin
            // Too short for the type field: flag it and drop what it claims.
            bytes_left_next = len_merged;
            res_valid       = 1'b1;
            res.last        = 1'b1;
            res.malformed   = 1'b1;
            if (len_merged == 32'd0) begin
              phase_next         = start_phase;
              byte_in_group_next = 2'd0;
            end else begin
              phase_next = PH_DROP;
            end
          end else begin
            type_accumulator_next = '0;
            phase_next            = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        type_accumulator_next = type_merged;
        if (type_done) begin
          bytes_left_next = plen;
          if (plen == 32'd0) begin
            res_valid          = 1'b1;
            res.msg_type       = type_merged;
            res.last           = 1'b1;
            phase_next         = start_phase;
            byte_in_group_next = 2'd0;
          end else begin
            phase_next = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        bytes_left_next    = left_dec;
        res_valid          = 1'b1;
        res.payload_byte   = plain;
        res.has_byte       = 1'b1;
        res.msg_type       = type_accumulator;
        res.payload_length = plen;
        res.last           = (left_dec == 32'd0);
        if (left_dec == 32'd0) begin
          phase_next         = start_phase;
          byte_in_group_next = 2'd0;
        end
      end
      PH_DROP: begin
        if (bytes_left != 32'd0) begin
          bytes_left_next = left_dec;
        end
        if (bytes_left <= 32'd1) begin
          phase_next         = start_phase;
          byte_in_group_next = 2'd0;
        end
      end
      default: begin
        phase_next         = start_phase;
        byte_in_group_next = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obfuscation_on   <= 1'b0;
      wide_type        <= 1'b1;
      phase            <= PH_LEN;
      byte_in_group    <= 2'd0;
      rolling_key      <= '0;
      frame_length     <= '0;
      bytes_left       <= '0;
      type_accumulator <= '0;
    end else if (cfg_we) begin
      // Any write restarts the parser at the head of a frame.
      if (cfg_index == CFG_OBFUSCATION_ON) begin
        obfuscation_on <= cfg_data[0];
        phase          <= cfg_data[0] ? PH_KEY : PH_LEN;
      end else begin
        phase <= start_phase;
      end
      if (cfg_index == CFG_WIDE_TYPE) begin
        wide_type <= cfg_data[0];
      end
      byte_in_group <= 2'd0;
    end else if (fire) begin
      phase            <= phase_next;
      byte_in_group    <= byte_in_group_next;
      rolling_key      <= rolling_key_next;
      frame_length     <= frame_length_next;
      bytes_left       <= bytes_left_next;
      type_accumulator <= type_accumulator_next;
    end
  end

endmodule

// ----- rtl/core/omd_out_reg.sv -----
// ----------------------------------------------------------------------------
// omd_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module omd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  omd_pkg::omd_result_t load_res,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output omd_pkg::omd_result_t out_res
);
  import omd_pkg::*;

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

// ----- rtl/core/obfuscated_message_deframer_top.sv -----
// ----------------------------------------------------------------------------
// obfuscated_message_deframer_top
// Parses length-prefixed frames from a byte stream, one byte per cycle. A
// frame is an optional 4-byte key (obfuscation on), a 4-byte little-endian
// length, a 1- or 4-byte type and the payload; with obfuscation on each byte
// after the key is XORed with a rolling key that turns left one bit per group
// of four bytes. Each payload byte yields one result; an empty payload yields
// one result without a byte, and a length shorter than the type field yields
// one malformed result and the claimed bytes are dropped. A byte is accepted
// every cycle and its result, if any, is registered: the byte sits in the
// input register and passes through the parser into the result register.
// Throughput stalls only when the result register is full and not being
// taken. A configuration write restarts the parser at a frame head.
// ----------------------------------------------------------------------------
module obfuscated_message_deframer_top (
  input  logic          clk,
  input  logic          rst,
  omd_byte_if.sink      rx_bytes,
  omd_result_if.source  msgs,
  omd_cfg_if.sink       cfg
);
  import omd_pkg::*;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        fire;
  logic        space;
  logic        res_valid;
  omd_result_t res;
  omd_result_t out_res;

  assign fire      = held_valid && space;
  assign cfg.ready = 1'b1;

  omd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx_bytes.valid),
    .in_byte    (rx_bytes.in_byte),
    .in_ready   (rx_bytes.ready),
    .fire       (fire),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  omd_parse_core u_parse_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.reg_index),
    .cfg_data  (cfg.data),
    .fire      (fire),
    .in_byte   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  omd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .load_res  (res),
    .space     (space),
    .out_valid (msgs.valid),
    .out_ready (msgs.ready),
    .out_res   (out_res)
  );

  assign msgs.payload_byte   = out_res.payload_byte;
  assign msgs.has_byte       = out_res.has_byte;
  assign msgs.msg_type       = out_res.msg_type;
  assign msgs.payload_length = out_res.payload_length;
  assign msgs.last           = out_res.last;
  assign msgs.malformed      = out_res.malformed;

`ifndef SYNTHESIS
  // A malformed marker closes its frame and carries no byte, type or length.
  assert property (@(posedge clk) disable iff (rst)
    msgs.valid && msgs.malformed |->
      msgs.last && !msgs.has_byte && msgs.msg_type == 32'd0 && msgs.payload_length == 32'd0)
    else $error("malformed result with stray fields");

  // Results without data carry a zero byte.
  assert property (@(posedge clk) disable iff (rst)
    msgs.valid && !msgs.has_byte |-> msgs.payload_byte == 8'd0)
    else $error("empty result with nonzero byte");

  // A data byte belongs to a frame with a nonempty payload.
  assert property (@(posedge clk) disable iff (rst)
    msgs.valid && msgs.has_byte |-> msgs.payload_length != 32'd0 && !msgs.malformed)
    else $error("payload byte in an empty or malformed frame");
`endif

endmodule
